>>> rtl/core/integer_expression_evaluator_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the integer expression evaluator
// Two property macros, one for a same-cycle implication and one for a
// next-cycle implication. Both sample on clk and are disabled in reset.
// ----------------------------------------------------------------------------
`ifndef INTEGER_EXPRESSION_EVALUATOR_ASSERT_SVH
`define INTEGER_EXPRESSION_EVALUATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IEE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IEE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/iee_pkg.sv
// ----------------------------------------------------------------------------
// Integer expression evaluator package
// Character codes, operator and status codes shared by the evaluator files.
// ----------------------------------------------------------------------------
package iee_pkg;

  // Default data width of the evaluator.
  localparam int VALUE_WIDTH_DEF = 32;

  // Result status.
  typedef logic [1:0] status_t;
  localparam status_t ERR_NONE = 2'd0;
  localparam status_t ERR_DIV0 = 2'd1;
  localparam status_t ERR_CHAR = 2'd2;

  // How the next operand joins the product term.
  typedef logic [1:0] term_op_t;
  localparam term_op_t OP_SET = 2'd0;
  localparam term_op_t OP_MUL = 2'd1;
  localparam term_op_t OP_DIV = 2'd2;

  // What follows once the pending operand has been closed.
  typedef logic [1:0] kind_t;
  localparam kind_t KIND_ADD    = 2'd0;
  localparam kind_t KIND_MULDIV = 2'd1;
  localparam kind_t KIND_FIN    = 2'd2;

  // Characters of the expression.
  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_STAR  = 8'h2A;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

endpackage

>>> rtl/core/integer_expression_evaluator.sv
// ----------------------------------------------------------------------------
// Integer expression evaluator
// Evaluates an infix expression of decimal numbers and + - * / that arrives
// one character per word, with * and / binding tighter. All arithmetic runs
// on one shared adder under a small sequencer.
//
//   Channel  Direction  Fields                   Handshake
//   in       input      char_code[7:0], is_last  in_valid / in_ready
//   out      output     value[W-1:0], status     out_valid / out_ready
//
// A digit is multiplied by ten and then added in; a space is skipped. Closing
// an operand runs a shift-add multiply or a restoring divide (one quotient
// bit per cycle) where one is pending; closing a term adds it into the sum.
// The last word runs one more operand and term close. Reset is synchronous
// and clears the expression state at once. A result waiting on out_ready does
// not block new words; only the next final sum waits for it.
// ----------------------------------------------------------------------------
module integer_expression_evaluator #(
  parameter int VALUE_WIDTH = iee_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_char_code,
  input  logic                          in_is_last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [VALUE_WIDTH-1:0] out_value,
  output iee_pkg::status_t              out_status
);
  import iee_pkg::*;

  localparam int W     = VALUE_WIDTH;
  localparam int CNT_W = $clog2(VALUE_WIDTH);

  // Sequencer states.
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DIG0  = 4'd1;
  localparam logic [3:0] S_DIG1  = 4'd2;
  localparam logic [3:0] S_OPND  = 4'd3;
  localparam logic [3:0] S_MUL   = 4'd4;
  localparam logic [3:0] S_DNEGA = 4'd5;
  localparam logic [3:0] S_DNEGB = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_DFIX  = 4'd8;
  localparam logic [3:0] S_TERM  = 4'd9;

  logic [3:0]           state_r, state_nxt;
  logic [3:0]           ch_r, ch_nxt;
  logic                 last_r, last_nxt;
  kind_t                kind_r, kind_nxt;
  logic                 opbit_r, opbit_nxt;
  logic [W-1:0]         num_r, num_nxt;
  logic [W-1:0]         term_r, term_nxt;
  logic [W-1:0]         rem_r, rem_nxt;
  logic [W-1:0]         sum_r, sum_nxt;
  term_op_t             term_op_r, term_op_nxt;
  logic                 add_sign_r, add_sign_nxt;
  status_t              err_r, err_nxt;
  logic                 qneg_r, qneg_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic signed [W-1:0]  out_value_r, out_value_nxt;
  status_t              out_status_r, out_status_nxt;

  // Shared adder: a + b, or a - b when sub is set, with carry out.
  logic [W:0]   add_a, add_b;
  logic         add_sub;
  logic [W+1:0] add_res;
  logic         op_done;
  logic         cnt_last;

  assign add_res  = {1'b0, add_a} + {1'b0, add_b ^ {(W+1){add_sub}}} + (W+2)'(add_sub);
  assign cnt_last = (cnt_r == CNT_W'(VALUE_WIDTH - 1));

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

  // Sequencer and datapath next state.
  always_comb begin
    state_nxt      = state_r;
    ch_nxt         = ch_r;
    last_nxt       = last_r;
    kind_nxt       = kind_r;
    opbit_nxt      = opbit_r;
    num_nxt        = num_r;
    term_nxt       = term_r;
    rem_nxt        = rem_r;
    sum_nxt        = sum_r;
    term_op_nxt    = term_op_r;
    add_sign_nxt   = add_sign_r;
    err_nxt        = err_r;
    qneg_nxt       = qneg_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    add_a          = '0;
    add_b          = '0;
    add_sub        = 1'b0;
    op_done        = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ch_nxt   = in_char_code[3:0];
          last_nxt = in_is_last;
          priority if (in_char_code >= CHAR_0 && in_char_code <= CHAR_9) begin
            state_nxt = S_DIG0;
          end else if (in_char_code == CHAR_PLUS || in_char_code == CHAR_MINUS) begin
            kind_nxt  = KIND_ADD;
            opbit_nxt = (in_char_code == CHAR_MINUS);
            state_nxt = S_OPND;
          end else if (in_char_code == CHAR_STAR || in_char_code == CHAR_SLASH) begin
            kind_nxt  = KIND_MULDIV;
            opbit_nxt = (in_char_code == CHAR_SLASH);
            state_nxt = S_OPND;
          end else begin
            // Spaces are skipped; any other character is flagged.
            if (in_char_code != CHAR_SPACE && err_r == ERR_NONE) begin
              err_nxt = ERR_CHAR;
            end
            if (in_is_last) begin
              kind_nxt  = KIND_FIN;
              state_nxt = S_OPND;
            end
          end
        end
      end

      // number * 10 as (number << 3) + (number << 1).
      S_DIG0: begin
        add_a     = {1'b0, num_r << 3};
        add_b     = {1'b0, num_r << 1};
        num_nxt   = add_res[W-1:0];
        state_nxt = S_DIG1;
      end

      // Add the digit; the low nibble of an ASCII digit is its value.
      S_DIG1: begin
        add_a   = {1'b0, num_r};
        add_b   = (W+1)'(ch_r);
        num_nxt = add_res[W-1:0];
        if (last_r) begin
          kind_nxt  = KIND_FIN;
          state_nxt = S_OPND;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      // Join the pending number into the term.
      S_OPND: begin
        rem_nxt = '0;
        cnt_nxt = '0;
        unique case (term_op_r)
          OP_MUL: begin
            state_nxt = S_MUL;
          end
          OP_DIV: begin
            if (num_r == '0) begin
              if (err_r == ERR_NONE) begin
                err_nxt = ERR_DIV0;
              end
              term_nxt = '0;
              op_done  = 1'b1;
            end else begin
              qneg_nxt  = term_r[W-1] ^ num_r[W-1];
              state_nxt = S_DNEGA;
            end
          end
          default: begin
            term_nxt = num_r;
            op_done  = 1'b1;
          end
        endcase
      end

      // Shift-add multiply, low W bits of the product.
      S_MUL: begin
        add_a    = {1'b0, rem_r};
        add_b    = {1'b0, term_r};
        if (num_r[0]) begin
          rem_nxt = add_res[W-1:0];
        end
        term_nxt = term_r << 1;
        num_nxt  = num_r >> 1;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_last) begin
          term_nxt = num_r[0] ? add_res[W-1:0] : rem_r;
          op_done  = 1'b1;
        end
      end

      // Dividend magnitude.
      S_DNEGA: begin
        add_b   = {1'b0, term_r};
        add_sub = 1'b1;
        if (term_r[W-1]) begin
          term_nxt = add_res[W-1:0];
        end
        state_nxt = S_DNEGB;
      end

      // Divisor magnitude.
      S_DNEGB: begin
        add_b   = {1'b0, num_r};
        add_sub = 1'b1;
        if (num_r[W-1]) begin
          num_nxt = add_res[W-1:0];
        end
        state_nxt = S_DIV;
      end

      // Restoring division, one quotient bit per cycle into term.
      S_DIV: begin
        add_a    = {rem_r, term_r[W-1]};
        add_b    = {1'b0, num_r};
        add_sub  = 1'b1;
        rem_nxt  = add_res[W+1] ? add_res[W-1:0] : add_a[W-1:0];
        term_nxt = {term_r[W-2:0], add_res[W+1]};
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_last) begin
          state_nxt = S_DFIX;
        end
      end

      // Quotient sign; truncation toward zero falls out of the magnitudes.
      S_DFIX: begin
        add_b   = {1'b0, term_r};
        add_sub = 1'b1;
        if (qneg_r) begin
          term_nxt = add_res[W-1:0];
        end
        op_done = 1'b1;
      end

      // Join the term into the sum.
      S_TERM: begin
        add_a   = {1'b0, sum_r};
        add_b   = {1'b0, term_r};
        add_sub = add_sign_r;
        if (kind_r == KIND_FIN) begin
          if (!out_valid_r || out_ready) begin
            out_valid_nxt  = 1'b1;
            out_value_nxt  = (err_r == ERR_NONE) ? $signed(add_res[W-1:0]) : '0;
            out_status_nxt = err_r;
            sum_nxt        = '0;
            term_nxt       = '0;
            num_nxt        = '0;
            term_op_nxt    = OP_SET;
            add_sign_nxt   = 1'b0;
            err_nxt        = ERR_NONE;
            state_nxt      = S_IDLE;
          end
        end else begin
          sum_nxt      = add_res[W-1:0];
          term_nxt     = '0;
          term_op_nxt  = OP_SET;
          add_sign_nxt = opbit_r;
          if (last_r) begin
            kind_nxt  = KIND_FIN;
            state_nxt = S_OPND;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Common tail of every operand close.
    if (op_done) begin
      num_nxt = '0;
      if (kind_r == KIND_MULDIV) begin
        term_op_nxt = opbit_r ? OP_DIV : OP_MUL;
        if (last_r) begin
          kind_nxt  = KIND_FIN;
          state_nxt = S_OPND;
        end else begin
          state_nxt = S_IDLE;
        end
      end else begin
        state_nxt = S_TERM;
      end
    end
  end

  // Control and expression state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      num_r       <= '0;
      term_r      <= '0;
      sum_r       <= '0;
      term_op_r   <= OP_SET;
      add_sign_r  <= 1'b0;
      err_r       <= ERR_NONE;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      num_r       <= num_nxt;
      term_r      <= term_nxt;
      sum_r       <= sum_nxt;
      term_op_r   <= term_op_nxt;
      add_sign_r  <= add_sign_nxt;
      err_r       <= err_nxt;
    end
  end

  // Word and scratch registers.
  always_ff @(posedge clk) begin
    ch_r         <= ch_nxt;
    last_r       <= last_nxt;
    kind_r       <= kind_nxt;
    opbit_r      <= opbit_nxt;
    rem_r        <= rem_nxt;
    qneg_r       <= qneg_nxt;
    cnt_r        <= cnt_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

endmodule

>>> rtl/core/iee_checker.sv
// ----------------------------------------------------------------------------
// Integer expression evaluator checker
// Port-level properties of the evaluator, bound to its top level.
// ----------------------------------------------------------------------------
`include "integer_expression_evaluator_assert.svh"

module iee_checker #(
  parameter int VALUE_WIDTH = iee_pkg::VALUE_WIDTH_DEF
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [7:0]                    in_char_code,
  input logic                          in_is_last,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [VALUE_WIDTH-1:0] out_value,
  input iee_pkg::status_t              out_status
);
  import iee_pkg::*;

  // A flagged result carries a zero value.
  `IEE_ASSERT_IMP(a_err_value_zero, out_valid && out_status != ERR_NONE, out_value == '0, "error result with nonzero value")

  // A result that is not taken holds.
  `IEE_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_value) && $stable(out_status), "stalled result word changed")

  // The last word always starts the final close, so the input goes busy.
  `IEE_ASSERT_NXT(a_last_busy, in_valid && in_ready && in_is_last, !in_ready, "input ready right after a last word")

  // A new result only comes out of the busy final close.
  `IEE_ASSERT_IMP(a_result_from_busy, $rose(out_valid), $past(!in_ready), "result appeared without a busy cycle")

endmodule

bind integer_expression_evaluator iee_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_iee_checker (.*);

>>> tb/integer_expression_evaluator_checker.sv
// ----------------------------------------------------------------------------
// Integer expression evaluator checker
// Watches both channels of the evaluator. Every accepted input word is run
// through a cycle-free model of the expression state, and every final word
// queues the value and status that the block must return. Each accepted
// result is compared field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module integer_expression_evaluator_checker #(
  parameter int W = iee_pkg::VALUE_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [7:0]          in_char_code,
  input  logic                in_is_last,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic signed [W-1:0] out_value,
  input  iee_pkg::status_t    out_status,
  output int                  fail_count,
  output int                  pending_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import iee_pkg::*;

  // Mismatch lines beyond this many are counted but not printed.
  localparam int PRINT_CAP = 100;

  typedef struct {
    logic [W-1:0] value;
    status_t      status;
  } expr_result_t;

  // Results still owed by the block, oldest first.
  expr_result_t owed_results[$];
  expr_result_t oldest;

  // Running state of the expression being read.
  logic [W-1:0] number_acc;
  logic [W-1:0] term_acc;
  logic [W-1:0] sum_acc;
  term_op_t     join_op;
  logic         subtract_term;
  status_t      first_error;

  initial begin
    fail_count    = 0;
    pending_count = 0;
  end

  task automatic report_mismatch(input string what, input logic signed [W-1:0] got,
                                 input logic signed [W-1:0] want);
    if (fail_count < PRINT_CAP) begin
      $display("MISMATCH %s: got %0d, wanted %0d at %0t", what, got, want, $realtime);
    end
    fail_count++;
  endtask

  function automatic void clear_expression();
    number_acc    = '0;
    term_acc      = '0;
    sum_acc       = '0;
    join_op       = OP_SET;
    subtract_term = 1'b0;
    first_error   = ERR_NONE;
  endfunction

  // Signed division that truncates toward zero, done on magnitudes.
  function automatic logic [W-1:0] quotient_toward_zero(input logic [W-1:0] a,
                                                        input logic [W-1:0] b);
    logic [W-1:0] mag_a;
    logic [W-1:0] mag_b;
    logic [W-1:0] quo;
    mag_a = a[W-1] ? -a : a;
    mag_b = b[W-1] ? -b : b;
    quo   = mag_a / mag_b;
    return (a[W-1] ^ b[W-1]) ? -quo : quo;
  endfunction

  function automatic void note_error(input status_t code);
    if (first_error == ERR_NONE) begin
      first_error = code;
    end
  endfunction

  // Join the pending number into the product term.
  function automatic void close_operand();
    case (join_op)
      OP_MUL: begin
        term_acc = term_acc * number_acc;
      end
      OP_DIV: begin
        if (number_acc == '0) begin
          note_error(ERR_DIV0);
          term_acc = '0;
        end else begin
          term_acc = quotient_toward_zero(term_acc, number_acc);
        end
      end
      default: begin
        term_acc = number_acc;
      end
    endcase
    number_acc = '0;
  endfunction

  // Join the product term into the sum.
  function automatic void close_term();
    sum_acc  = subtract_term ? sum_acc - term_acc : sum_acc + term_acc;
    term_acc = '0;
    join_op  = OP_SET;
  endfunction

  // Advance the expression by one word and queue the result on the last one.
  function automatic void take_word(input logic [7:0] code, input logic last);
    if (code >= CHAR_0 && code <= CHAR_9) begin
      number_acc = number_acc * W'(10) + (W'(code) - W'(CHAR_0));
    end else if (code == CHAR_PLUS || code == CHAR_MINUS) begin
      close_operand();
      close_term();
      subtract_term = (code == CHAR_MINUS);
    end else if (code == CHAR_STAR || code == CHAR_SLASH) begin
      close_operand();
      join_op = (code == CHAR_STAR) ? OP_MUL : OP_DIV;
    end else if (code != CHAR_SPACE) begin
      note_error(ERR_CHAR);
    end
    if (last) begin
      close_operand();
      close_term();
      oldest.value  = (first_error == ERR_NONE) ? sum_acc : '0;
      oldest.status = first_error;
      owed_results.push_back(oldest);
      clear_expression();
    end
  endfunction

  // Inputs are taken before results, so a result in the same cycle as its
  // last word would still find its expectation.
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_expression();
      owed_results.delete();
    end else begin
      if (in_valid && in_ready) begin
        take_word(in_char_code, in_is_last);
      end
      if (out_valid && out_ready) begin
        if (owed_results.size() == 0) begin
          report_mismatch("result with no expression pending", out_value, '0);
        end else begin
          oldest = owed_results.pop_front();
          if (out_value !== oldest.value) begin
            report_mismatch("value", out_value, oldest.value);
          end
          if (out_status !== oldest.status) begin
            report_mismatch("status", W'(out_status), W'(oldest.status));
          end
        end
      end
    end
    pending_count <= owed_results.size();
  end

endmodule

>>> tb/integer_expression_evaluator_tb.sv
// ----------------------------------------------------------------------------
// Integer expression evaluator testbench
// Feeds expressions one character word at a time: a directed set for the
// extremes and corner cases, then random expressions, most well formed with
// random numbers, spacing and operators, the rest broken or pure noise. Both
// sides idle at random, and the result side holds off long enough to stall
// the input. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module integer_expression_evaluator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import iee_pkg::*;

  localparam int W           = VALUE_WIDTH_DEF;
  localparam int WORD_TARGET = 1150;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 5000;
  localparam int TAIL_CYCLES = 60;

  logic                clk          = 1'b0;
  logic                rst_n        = 1'b0;
  logic                in_valid     = 1'b0;
  logic                in_ready;
  logic [7:0]          in_char_code = 8'h00;
  logic                in_is_last   = 1'b0;
  logic                out_valid;
  logic                out_ready    = 1'b0;
  logic signed [W-1:0] out_value;
  status_t             out_status;

  int fail_count;
  int pending_count;
  int stalled_cycles = 0;
  int sent_words     = 0;
  int holds_asked    = 0;
  int holds_served   = 0;
  bit steady         = 1'b0;

  // Characters of the expression being sent.
  logic [7:0] expr_text[$];

  integer_expression_evaluator #(
    .VALUE_WIDTH(W)
  ) u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_char_code(in_char_code),
    .in_is_last  (in_is_last),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_value   (out_value),
    .out_status  (out_status)
  );

  integer_expression_evaluator_checker #(
    .W(W)
  ) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_char_code (in_char_code),
    .in_is_last   (in_is_last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_value    (out_value),
    .out_status   (out_status),
    .fail_count   (fail_count),
    .pending_count(pending_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int idle_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] any_operator();
    case ($urandom_range(0, 3))
      0:       return CHAR_PLUS;
      1:       return CHAR_MINUS;
      2:       return CHAR_STAR;
      default: return CHAR_SLASH;
    endcase
  endfunction

  task automatic append_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      expr_text.push_back(s[i]);
    end
  endtask

  // Mostly short numbers, some long enough to wrap, with a rare inner space.
  task automatic append_number();
    int roll;
    int digits;
    roll   = $urandom_range(0, 99);
    digits = (roll < 70) ? $urandom_range(1, 3) :
             (roll < 92) ? $urandom_range(4, 7) : $urandom_range(8, 12);
    repeat (digits) begin
      expr_text.push_back(CHAR_0 + 8'($urandom_range(0, 9)));
      if ($urandom_range(0, 24) == 0) expr_text.push_back(CHAR_SPACE);
    end
  endtask

  // A random expression: well formed most of the time, sometimes with a
  // leading, doubled or trailing operator or a stray byte, sometimes noise.
  task automatic compose_expression();
    int         n_terms;
    int         t;
    logic [7:0] stray;
    expr_text.delete();
    if ($urandom_range(0, 99) < 8) begin
      repeat ($urandom_range(1, 8)) expr_text.push_back(8'($urandom_range(0, 255)));
    end else begin
      n_terms = $urandom_range(1, 5);
      if ($urandom_range(0, 9) == 0) expr_text.push_back(any_operator());
      for (t = 0; t < n_terms; t++) begin
        if ($urandom_range(0, 7) == 0) expr_text.push_back(CHAR_SPACE);
        append_number();
        if ($urandom_range(0, 7) == 0) expr_text.push_back(CHAR_SPACE);
        if (t < n_terms - 1) begin
          expr_text.push_back(any_operator());
          if ($urandom_range(0, 19) == 0) expr_text.push_back(any_operator());
        end
      end
      if ($urandom_range(0, 11) == 0) expr_text.push_back(any_operator());
      if ($urandom_range(0, 11) == 0) begin
        do begin
          stray = 8'($urandom_range(0, 255));
        end while ((stray >= CHAR_0 && stray <= CHAR_9) || stray == CHAR_PLUS ||
                   stray == CHAR_MINUS || stray == CHAR_STAR || stray == CHAR_SLASH ||
                   stray == CHAR_SPACE);
        expr_text.insert($urandom_range(0, expr_text.size()), stray);
      end
    end
  endtask

  // Offer one word and hold it until it is accepted.
  task automatic send_word(input logic [7:0] code, input logic last);
    in_valid     <= 1'b1;
    in_char_code <= code;
    in_is_last   <= last;
    do @(posedge clk); while (!in_ready);
    sent_words++;
  endtask

  // Send the composed expression, flagging its final word.
  task automatic send_expression();
    int gap;
    for (int i = 0; i < expr_text.size(); i++) begin
      send_word(expr_text[i], i == expr_text.size() - 1);
      gap = steady ? 0 : idle_gap();
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Stop offering words until every owed result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  // Result side: random ready with gaps, and a long hold-off on request.
  initial begin
    int gap;
    while (!rst_n) @(posedge clk);
    forever begin
      if (holds_served != holds_asked) begin
        holds_served++;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        gap = steady ? 0 : idle_gap();
        if (gap != 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a word.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stalled_cycles <= 0;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
      if (stalled_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Leading plus, wrapped numbers giving the minimum value divided by
    // minus one, and a trailing minus that subtracts zero.
    expr_text.delete();
    append_text("+2147483648/4294967295-");
    send_expression();
    // Lowest and highest byte codes: an invalid character, then a division
    // by zero that must not replace the first error.
    expr_text.delete();
    expr_text.push_back(8'h00);
    expr_text.push_back(CHAR_SLASH);
    expr_text.push_back(8'hFF);
    send_expression();
    // Empty expression: only a space.
    expr_text.delete();
    expr_text.push_back(CHAR_SPACE);
    send_expression();
    // Multiply by a missing operand, then divide by zero.
    expr_text.delete();
    append_text("7*/0");
    send_expression();
    drain();

    // Hold the result side while more expressions queue up behind it.
    holds_asked++;
    repeat (6) begin
      compose_expression();
      send_expression();
    end
    drain();

    // Random expressions, with runs of no idling and the odd hold-off.
    while (sent_words < WORD_TARGET) begin
      steady = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 59) == 0) holds_asked++;
      compose_expression();
      send_expression();
      if ($urandom_range(0, 39) == 0) drain();
    end
    steady = 1'b0;
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/iee_pkg.sv
rtl/core/integer_expression_evaluator.sv
rtl/core/iee_checker.sv
tb/integer_expression_evaluator_checker.sv
tb/integer_expression_evaluator_tb.sv
